// File: rtl/gat_pkg.sv
// ----------------------------------------------------------------------------
// Generalised Anscombe transform package
// Shared widths, register indexes, fixed-point constants and pipeline
// sideband types for the transform core and its cells.
// ----------------------------------------------------------------------------
package gat_pkg;

  // Pixel format: unsigned Q16.8.
  localparam int PIXEL_WIDTH   = 24;
  localparam int FRACTION_BITS = 8;
  localparam logic [PIXEL_WIDTH-1:0] PIX_MAX = '1;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int GAIN_W      = 16;
  localparam int SIGMA_W     = 16;
  localparam int OFFSET_W    = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGMA     = 2'd3;

  // Squares of the gain and of sigma.
  localparam int SQ_W = 2 * GAIN_W;

  // Powers of the pixel.
  localparam int X2_W = 2 * PIXEL_WIDTH;
  localparam int X3_W = 3 * PIXEL_WIDTH;

  // Shift that takes a Q.8 product to the scale of the internal terms.
  localparam int FWD_SHIFT = FRACTION_BITS + 10;
  localparam int S2_SHIFT  = 2 * FRACTION_BITS + 2;

  // Quotient widths of the four divider lanes.
  localparam int QA_W = 60;
  localparam int QB_W = 25;
  localparam int QC_W = 35;
  localparam int QD_W = 42;

  // sqrt(3/2) in Q1.16.
  localparam longint unsigned SQRT_1P5_Q16 = 64'd80265;

  // Constant dividends of the inverse reciprocal terms.
  localparam logic [QB_W-1:0] DIVIDEND_B =
    QB_W'(SQRT_1P5_Q16 << (3 * FRACTION_BITS - 16));
  localparam logic [QC_W-1:0] DIVIDEND_C =
    QC_W'(64'd11 << (4 * FRACTION_BITS - 1));
  localparam logic [QD_W-1:0] DIVIDEND_D =
    QD_W'((64'd5 * SQRT_1P5_Q16) << (5 * FRACTION_BITS - 17));

  // The constant 1/8 at the internal scale.
  localparam int INV_SUM_W = 51;
  localparam logic [INV_SUM_W-1:0] INV_BIAS = INV_SUM_W'(64'd1 << (2 * FRACTION_BITS - 1));

  // Sideband through the divider chain.
  typedef struct packed {
    logic            x_zero;
    logic [X2_W-1:0] x2;
  } div_side_t;

  // Sideband through the square-root chain.
  typedef struct packed {
    logic                   sat;
    logic [PIXEL_WIDTH-1:0] res;
  } post_side_t;

endpackage

// File: rtl/generalized_anscombe_transform_core.sv
// ----------------------------------------------------------------------------
// Generalised Anscombe transform core
// Streaming per-pixel variance-stabilising transform and its closed-form
// inverse for Poisson-Gaussian noise, in unsigned Q16.8 fixed point.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock and returns one result per pixel, in
// order. Behind the front stages lies a row of 60 divider cells, each
// deciding one quotient bit of four parallel divisions, followed by a row
// of 24 square-root cells; every cell hands its work to the next one on each
// clock, so a new pixel enters every cycle unless the row is held.
// A one-entry skid buffer sits behind the last stage: the input stalls only
// while that buffer holds a result that the output side has not taken.
// Configuration writes are always ready and must be made only while no pixel
// is in flight. A zero gain is treated as the smallest gain, 1/256. Results
// that exceed the pixel range, and inverse inputs of zero, give the maximum
// value with the saturated flag set; negative results give zero.
module generalized_anscombe_transform_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Pixel input.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [gat_pkg::PIXEL_WIDTH-1:0]      value_in_i,
  // Result output.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [gat_pkg::PIXEL_WIDTH-1:0]      value_out_o,
  output logic                                 saturated_o,
  // Configuration writes.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gat_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [gat_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int PW     = gat_pkg::PIXEL_WIDTH;
  localparam int QA_W   = gat_pkg::QA_W;
  localparam int QB_W   = gat_pkg::QB_W;
  localparam int QC_W   = gat_pkg::QC_W;
  localparam int QD_W   = gat_pkg::QD_W;
  localparam int SQ_W   = gat_pkg::SQ_W;
  localparam int X2_W   = gat_pkg::X2_W;
  localparam int X3_W   = gat_pkg::X3_W;
  localparam int SUM_W  = gat_pkg::INV_SUM_W;
  localparam int ROOT_W = PW;
  localparam int REM_W  = 2 * PW;
  localparam int V_W    = X2_W + 1;
  localparam int LO_W   = 25;
  localparam int PROD_W = V_W + gat_pkg::GAIN_W + 1;
  // Four front stages, the divider row, five finishing stages, the root row
  // and the output register.
  localparam int LAT    = 4 + QA_W + 5 + ROOT_W + 1;

  // --------------------------------------------------------------------------
  // Configuration registers. The user must keep their values fixed while
  // pixels are in flight, unchecked by the block; every stage reads them directly.
  // --------------------------------------------------------------------------
  logic                          dir_q;
  logic [gat_pkg::GAIN_W-1:0]    gain_q;
  logic [gat_pkg::OFFSET_W-1:0]  offset_q;
  logic [gat_pkg::SIGMA_W-1:0]   sigma_q;
  logic [gat_pkg::GAIN_W-1:0]    gain_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= 1'b0;
      gain_q   <= 16'd256;
      offset_q <= '0;
      sigma_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gat_pkg::REG_DIRECTION: dir_q    <= cfg_data_i[0];
        gat_pkg::REG_GAIN:      gain_q   <= cfg_data_i[gat_pkg::GAIN_W-1:0];
        gat_pkg::REG_OFFSET:    offset_q <= cfg_data_i[gat_pkg::OFFSET_W-1:0];
        gat_pkg::REG_SIGMA:     sigma_q  <= cfg_data_i[gat_pkg::SIGMA_W-1:0];
        default: ;
      endcase
    end
  end

  // A gain of zero behaves as the smallest representable gain.
  assign gain_eff = (gain_q == '0) ? gat_pkg::GAIN_W'(1) : gain_q;

  // --------------------------------------------------------------------------
  // Flow control. The whole row advances together; it holds only while the
  // skid buffer is full.
  // --------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld_q;
  logic           skid_full_q;

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage P1: capture the pixel.
  // --------------------------------------------------------------------------
  logic [PW-1:0] p1_x_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_x_q <= value_in_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P2: squares and the signed difference x - mu.
  // --------------------------------------------------------------------------
  logic [X2_W-1:0] p2_x2_q;
  logic [SQ_W-1:0] p2_g2_q;
  logic [SQ_W-1:0] p2_s2_q;
  logic [PW+1:0]   p2_d_q;
  logic [PW-1:0]   p2_x_q;
  logic            p2_xz_q;
  logic [X2_W-1:0] x2_d;
  logic [SQ_W-1:0] g2_d;
  logic [SQ_W-1:0] s2_d;
  logic [PW+1:0]   mu_ext;

  assign x2_d   = p1_x_q * p1_x_q;
  assign g2_d   = gain_eff * gain_eff;
  assign s2_d   = sigma_q * sigma_q;
  assign mu_ext = {{2{offset_q[gat_pkg::OFFSET_W-1]}}, offset_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_x2_q <= x2_d;
      p2_g2_q <= g2_d;
      p2_s2_q <= s2_d;
      p2_d_q  <= {2'b00, p1_x_q} - mu_ext;
      p2_x_q  <= p1_x_q;
      p2_xz_q <= (p1_x_q == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage P3: partial products of x^3, the forward data term |x - mu| * g,
  // and the forward constant part 4*sigma^2 + (3/2)*g^2 at the internal scale.
  // --------------------------------------------------------------------------
  localparam int DT_W = PW + 1 + gat_pkg::GAIN_W;

  logic [2*PW-1:0]  p3_plo_q;
  logic [2*PW-1:0]  p3_phi_q;
  logic [DT_W-1:0]  p3_dterm_q;
  logic             p3_dneg_q;
  logic [QA_W-1:0]  p3_posbase_q;
  logic [SQ_W-1:0]  p3_s2_q;
  logic [SQ_W-1:0]  p3_g2_q;
  logic [X2_W-1:0]  p3_x2_q;
  logic [PW-1:0]    p3_x_q;
  logic             p3_xz_q;
  logic [PW+1:0]    d_neg;
  logic [PW:0]      mag;
  logic [2*PW-1:0]  plo_d;
  logic [2*PW-1:0]  phi_d;
  logic [DT_W-1:0]  dterm_d;

  assign d_neg   = -p2_d_q;
  assign mag     = p2_d_q[PW+1] ? d_neg[PW:0] : p2_d_q[PW:0];
  assign plo_d   = p2_x2_q[PW-1:0] * p2_x_q;
  assign phi_d   = p2_x2_q[X2_W-1:PW] * p2_x_q;
  assign dterm_d = mag * gain_eff;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_plo_q     <= plo_d;
      p3_phi_q     <= phi_d;
      p3_dterm_q   <= dterm_d;
      p3_dneg_q    <= p2_d_q[PW+1];
      p3_posbase_q <= (QA_W'(p2_s2_q) << gat_pkg::S2_SHIFT)
                    + (QA_W'(p2_g2_q) << (2 * gat_pkg::FRACTION_BITS))
                    + (QA_W'(p2_g2_q) << (2 * gat_pkg::FRACTION_BITS - 1));
      p3_s2_q      <= p2_s2_q;
      p3_g2_q      <= p2_g2_q;
      p3_x2_q      <= p2_x2_q;
      p3_x_q       <= p2_x_q;
      p3_xz_q      <= p2_xz_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P4: x^3, the forward dividend and the loading of the divider row.
  // Lane A divides by g^2: the forward argument, or 4*sigma^2 in the inverse.
  // Lanes B, C and D divide constants by x, x^2 and x^3.
  // --------------------------------------------------------------------------
  logic [QA_W-1:0] p4_a_num_q;
  logic [SQ_W-1:0] p4_a_den_q;
  logic [PW-1:0]   p4_b_den_q;
  logic [X2_W-1:0] p4_c_den_q;
  logic [X3_W-1:0] p4_d_den_q;
  logic [QA_W-1:0] dterm_sh;
  logic [QA_W:0]   fwd_diff;
  logic [QA_W-1:0] fwd_num;
  logic [X3_W-1:0] x3_d;

  assign dterm_sh = QA_W'(p3_dterm_q) << gat_pkg::FWD_SHIFT;
  assign fwd_diff = {1'b0, p3_posbase_q} - {1'b0, dterm_sh};
  // A negative argument under the root gives a zero dividend and so zero.
  assign fwd_num  = p3_dneg_q ? (fwd_diff[QA_W] ? '0 : fwd_diff[QA_W-1:0])
                              : (p3_posbase_q + dterm_sh);
  assign x3_d     = X3_W'(p3_plo_q) + (X3_W'(p3_phi_q) << PW);

  gat_pkg::div_side_t dside_q [0:QA_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_a_num_q <= dir_q ? (QA_W'(p3_s2_q) << gat_pkg::S2_SHIFT) : fwd_num;
      p4_a_den_q <= p3_g2_q;
      p4_b_den_q <= p3_x_q;
      p4_c_den_q <= p3_x2_q;
      p4_d_den_q <= x3_d;
      dside_q[0] <= '{x_zero: p3_xz_q, x2: p3_x2_q};
      for (int k = 1; k <= QA_W; k++) begin
        dside_q[k] <= dside_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider row: cell k decides quotient bit QA_W-1-k of all four lanes.
  // --------------------------------------------------------------------------
  wire [QA_W-1:0] a_rem [0:QA_W];
  wire [SQ_W-1:0] a_den [0:QA_W];
  wire [QA_W-1:0] a_quo [0:QA_W];
  wire [QB_W-1:0] b_rem [0:QA_W];
  wire [PW-1:0]   b_den [0:QA_W];
  wire [QB_W-1:0] b_quo [0:QA_W];
  wire [QC_W-1:0] c_rem [0:QA_W];
  wire [X2_W-1:0] c_den [0:QA_W];
  wire [QC_W-1:0] c_quo [0:QA_W];
  wire [QD_W-1:0] d_rem [0:QA_W];
  wire [X3_W-1:0] d_den [0:QA_W];
  wire [QD_W-1:0] d_quo [0:QA_W];

  assign a_rem[0] = p4_a_num_q;
  assign a_den[0] = p4_a_den_q;
  assign a_quo[0] = '0;
  assign b_rem[0] = gat_pkg::DIVIDEND_B;
  assign b_den[0] = p4_b_den_q;
  assign b_quo[0] = '0;
  assign c_rem[0] = gat_pkg::DIVIDEND_C;
  assign c_den[0] = p4_c_den_q;
  assign c_quo[0] = '0;
  assign d_rem[0] = gat_pkg::DIVIDEND_D;
  assign d_den[0] = p4_d_den_q;
  assign d_quo[0] = '0;

  for (genvar k = 0; k < QA_W; k++) begin : g_div
    gat_div_cell #(.NUM_W(QA_W), .DEN_W(SQ_W), .BIT(QA_W - 1 - k)) u_lane_a (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (a_rem[k]),
      .den_i (a_den[k]),
      .quo_i (a_quo[k]),
      .rem_o (a_rem[k+1]),
      .den_o (a_den[k+1]),
      .quo_o (a_quo[k+1])
    );
    gat_div_cell #(.NUM_W(QB_W), .DEN_W(PW), .BIT(QA_W - 1 - k)) u_lane_b (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (b_rem[k]),
      .den_i (b_den[k]),
      .quo_i (b_quo[k]),
      .rem_o (b_rem[k+1]),
      .den_o (b_den[k+1]),
      .quo_o (b_quo[k+1])
    );
    gat_div_cell #(.NUM_W(QC_W), .DEN_W(X2_W), .BIT(QA_W - 1 - k)) u_lane_c (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (c_rem[k]),
      .den_i (c_den[k]),
      .quo_i (c_quo[k]),
      .rem_o (c_rem[k+1]),
      .den_o (c_den[k+1]),
      .quo_o (c_quo[k+1])
    );
    gat_div_cell #(.NUM_W(QD_W), .DEN_W(X3_W), .BIT(QA_W - 1 - k)) u_lane_d (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (d_rem[k]),
      .den_i (d_den[k]),
      .quo_i (d_quo[k]),
      .rem_o (d_rem[k+1]),
      .den_o (d_den[k+1]),
      .quo_o (d_quo[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage Q1: forward saturation test and the inverse positive and negative
  // sums. In the forward direction the root exceeds the pixel range exactly
  // when the quotient reaches 2^(2*PW).
  // --------------------------------------------------------------------------
  logic             q1_fsat_q;
  logic [REM_W-1:0] q1_n_q;
  logic [SUM_W-1:0] q1_pos_q;
  logic [SUM_W-1:0] q1_neg_q;
  logic             q1_xz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_fsat_q <= |a_quo[QA_W][QA_W-1:REM_W];
      q1_n_q    <= a_quo[QA_W][REM_W-1:0];
      q1_pos_q  <= SUM_W'(dside_q[QA_W].x2) + SUM_W'(b_quo[QA_W]) + SUM_W'(d_quo[QA_W]);
      q1_neg_q  <= SUM_W'(c_quo[QA_W]) + gat_pkg::INV_BIAS + SUM_W'(a_quo[QA_W]);
      q1_xz_q   <= dside_q[QA_W].x_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Stage Q2: clamp the inverse polynomial at zero.
  // --------------------------------------------------------------------------
  logic             q2_fsat_q;
  logic [REM_W-1:0] q2_n_q;
  logic [V_W-1:0]   q2_v_q;
  logic             q2_xz_q;
  logic [SUM_W-1:0] inv_diff;

  assign inv_diff = q1_pos_q - q1_neg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q2_fsat_q <= q1_fsat_q;
      q2_n_q    <= q1_n_q;
      q2_v_q    <= (q1_pos_q > q1_neg_q) ? inv_diff[V_W-1:0] : '0;
      q2_xz_q   <= q1_xz_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages Q3 and Q4: v * g in two partial products, then rescale.
  // --------------------------------------------------------------------------
  localparam int MLO_W = LO_W + gat_pkg::GAIN_W;
  localparam int MHI_W = V_W - LO_W + gat_pkg::GAIN_W;

  logic             q3_fsat_q;
  logic [REM_W-1:0] q3_n_q;
  logic [MLO_W-1:0] q3_mlo_q;
  logic [MHI_W-1:0] q3_mhi_q;
  logic             q3_xz_q;
  logic [MLO_W-1:0] mlo_d;
  logic [MHI_W-1:0] mhi_d;

  assign mlo_d = q2_v_q[LO_W-1:0] * gain_eff;
  assign mhi_d = q2_v_q[V_W-1:LO_W] * gain_eff;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q3_fsat_q <= q2_fsat_q;
      q3_n_q    <= q2_n_q;
      q3_mlo_q  <= mlo_d;
      q3_mhi_q  <= mhi_d;
      q3_xz_q   <= q2_xz_q;
    end
  end

  localparam int BASE_W = PROD_W - gat_pkg::FWD_SHIFT;

  logic              q4_fsat_q;
  logic [REM_W-1:0]  q4_n_q;
  logic [BASE_W-1:0] q4_base_q;
  logic              q4_xz_q;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(q3_mlo_q) + (PROD_W'(q3_mhi_q) << LO_W);

  always_ff @(posedge clk_i) begin
    if (en) begin
      q4_fsat_q <= q3_fsat_q;
      q4_n_q    <= q3_n_q;
      q4_base_q <= prod[PROD_W-1:gat_pkg::FWD_SHIFT];
      q4_xz_q   <= q3_xz_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage Q5: add the offset, clamp and settle the saturation flag. The
  // forward root then starts from the quotient in the root row.
  // --------------------------------------------------------------------------
  localparam int R_W = BASE_W + 2;

  logic [REM_W-1:0]    q5_n_q;
  logic [R_W-1:0]      inv_r;
  logic                inv_over;
  gat_pkg::post_side_t post_d;
  gat_pkg::post_side_t psd_q [0:ROOT_W];

  assign inv_r    = {2'b00, q4_base_q} + R_W'($signed(offset_q));
  assign inv_over = !inv_r[R_W-1] && (inv_r[R_W-2:PW] != '0);

  always_comb begin
    post_d.sat = dir_q ? (q4_xz_q || inv_over) : q4_fsat_q;
    post_d.res = inv_r[R_W-1] ? '0 : inv_r[PW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q5_n_q   <= q4_n_q;
      psd_q[0] <= post_d;
      for (int j = 1; j <= ROOT_W; j++) begin
        psd_q[j] <= psd_q[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square-root row: cell j decides root bit ROOT_W-1-j.
  // --------------------------------------------------------------------------
  wire [REM_W-1:0]  sq_rem  [0:ROOT_W];
  wire [ROOT_W-1:0] sq_root [0:ROOT_W];

  assign sq_rem[0]  = q5_n_q;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    gat_sqrt_cell #(.REM_W(REM_W), .ROOT_W(ROOT_W), .J(ROOT_W - 1 - j)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output register and skid buffer.
  // --------------------------------------------------------------------------
  logic [PW-1:0] out_res_q;
  logic          out_sat_q;
  logic [PW-1:0] skid_res_q;
  logic          skid_sat_q;
  logic          last_vld;

  assign last_vld = vld_q[LAT-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_sat_q <= psd_q[ROOT_W].sat;
      if (psd_q[ROOT_W].sat) begin
        out_res_q <= gat_pkg::PIX_MAX;
      end else begin
        out_res_q <= dir_q ? psd_q[ROOT_W].res : sq_root[ROOT_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (!out_stall_i) begin
        skid_full_q <= 1'b0;
      end
    end else if (last_vld && out_stall_i) begin
      skid_full_q <= 1'b1;
    end
  end

  // While empty the buffer shadows the output register, so a stalled result
  // is already held here when the row moves on.
  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      skid_res_q <= out_res_q;
      skid_sat_q <= out_sat_q;
    end
  end

  assign out_valid_o = skid_full_q || last_vld;
  assign value_out_o = skid_full_q ? skid_res_q : out_res_q;
  assign saturated_o = skid_full_q ? skid_sat_q : out_sat_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_full_q) |-> $past(last_vld && out_stall_i))
    else $error("skid buffer filled without a stalled result");

  a_row_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |=> $stable(vld_q))
    else $error("pipeline moved while the skid buffer was full");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("transferred pixel did not enter the pipeline");

  a_sat_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> value_out_o == gat_pkg::PIX_MAX)
    else $error("saturated result is not the maximum value");

endmodule

// File: rtl/gat_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step of a long division: decides a single quotient bit and
// registers remainder, divisor and partial quotient for the next cell.
// ----------------------------------------------------------------------------
module gat_div_cell #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 32,
  parameter int BIT   = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] rem_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [NUM_W-1:0] quo_i,
  output logic [NUM_W-1:0] rem_o,
  output logic [DEN_W-1:0] den_o,
  output logic [NUM_W-1:0] quo_o
);

  logic [NUM_W-1:0] rem_d;
  logic [NUM_W-1:0] quo_d;

  if (BIT < NUM_W) begin : g_step
    localparam int CW = (DEN_W + BIT > NUM_W) ? DEN_W + BIT : NUM_W;
    logic [CW-1:0] dsh;
    logic [CW-1:0] diff;
    logic          fits;

    assign dsh   = CW'(den_i) << BIT;
    assign fits  = dsh <= CW'(rem_i);
    assign diff  = CW'(rem_i) - dsh;
    assign rem_d = fits ? diff[NUM_W-1:0] : rem_i;
    assign quo_d = fits ? (quo_i | (NUM_W'(1) << BIT)) : quo_i;
  end else begin : g_pass
    // The shifted divisor is wider than any remainder, so the bit is zero.
    assign rem_d = rem_i;
    assign quo_d = quo_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      den_o <= den_i;
      quo_o <= quo_d;
    end
  end

endmodule

// File: rtl/gat_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square-root cell
// One digit-by-digit step of an integer square root: decides a single root
// bit and registers the remainder and partial root for the next cell.
// ----------------------------------------------------------------------------
module gat_sqrt_cell #(
  parameter int REM_W  = 48,
  parameter int ROOT_W = 24,
  parameter int J      = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic [REM_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam logic [REM_W:0] ONE_SQ = (REM_W + 1)'(1) << (2 * J);

  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              fits;
  logic [REM_W-1:0]  rem_d;
  logic [ROOT_W-1:0] root_d;

  // (R + 2^J)^2 - R^2 = R * 2^(J+1) + 2^(2J); the two parts never overlap.
  assign trial  = ((REM_W + 1)'(root_i) << (J + 1)) | ONE_SQ;
  assign fits   = {1'b0, rem_i} >= trial;
  assign diff   = {1'b0, rem_i} - trial;
  assign rem_d  = fits ? diff[REM_W-1:0] : rem_i;
  assign root_d = fits ? (root_i | (ROOT_W'(1) << J)) : root_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

endmodule

// File: sim/gat_result_checker.sv
// ----------------------------------------------------------------------------
// Generalised Anscombe transform result checker
// Watches the pixel, result and configuration channels of the core, keeps its
// own copy of the registers, predicts each result and compares it in order.
// ----------------------------------------------------------------------------
module gat_result_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [gat_pkg::PIXEL_WIDTH-1:0]    value_in_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [gat_pkg::PIXEL_WIDTH-1:0]    value_out_i,
  input  logic                               saturated_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [gat_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [gat_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output int                                 error_count_o,
  output int                                 pending_count_o,
  output int                                 checked_count_o
);
  import gat_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [PIXEL_WIDTH-1:0] value;
    logic                   sat;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];

  logic                   inverse_mode;
  logic [GAIN_W-1:0]      gain_q88;
  logic [OFFSET_W-1:0]    offset_q168;
  logic [SIGMA_W-1:0]     sigma_q88;
  bit                     arith_ovf;

  // Saturating helpers: any overflow sets arith_ovf and forces the maximum.
  function automatic u64_t clip_mul(u64_t a, u64_t b);
    logic [127:0] p;
    p = a * b;
    if (p[127:64] != 0) begin
      arith_ovf = 1'b1;
      return '1;
    end
    return p[63:0];
  endfunction

  function automatic u64_t clip_add(u64_t a, u64_t b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      arith_ovf = 1'b1;
      return '1;
    end
    return s[63:0];
  endfunction

  function automatic u64_t clip_shl(u64_t a, int unsigned s);
    if (a == 0) return 0;
    if (s >= 64 || a > (u64_t'('1) >> s)) begin
      arith_ovf = 1'b1;
      return '1;
    end
    return a << s;
  endfunction

  function automatic u64_t int_sqrt(u64_t n);
    u64_t root;
    u64_t one;
    root = 0;
    one  = u64_t'(1) << 62;
    while (one > n) one = one >> 2;
    while (one != 0) begin
      if (n >= root + one) begin
        n    = n - (root + one);
        root = (root >> 1) + one;
      end else begin
        root = root >> 1;
      end
      one = one >> 2;
    end
    return root;
  endfunction

  function automatic pixel_result_t predict_pixel(logic [PIXEL_WIDTH-1:0] pixel);
    pixel_result_t r;
    u64_t   x, g, g2, s2, mag, dterm, pos, neg, res, t0, t1, t2, t3, sg, v, base;
    longint mu, d, sum;
    x   = u64_t'(pixel);
    g   = (gain_q88 == 0) ? 1 : u64_t'(gain_q88);
    g2  = g * g;
    s2  = u64_t'(sigma_q88) * u64_t'(sigma_q88);
    mu  = longint'($signed(offset_q168));
    res = 0;
    arith_ovf = 1'b0;
    if (!inverse_mode) begin
      d     = longint'(x) - mu;
      mag   = (d < 0) ? u64_t'(-d) : u64_t'(d);
      dterm = clip_mul(clip_shl(mag, FWD_SHIFT), g);
      pos   = clip_add(clip_shl(s2, S2_SHIFT), clip_shl(clip_mul(3, g2), 2 * FRACTION_BITS - 1));
      neg   = 0;
      if (d < 0) neg = dterm;
      else pos = clip_add(pos, dterm);
      if (!arith_ovf) res = (neg >= pos) ? 0 : int_sqrt((pos - neg) / g2);
    end else if (x == 0) begin
      // A zero stabilised value has no inverse: it saturates.
      arith_ovf = 1'b1;
    end else begin
      t0   = clip_mul(x, x);
      t1   = (clip_shl(SQRT_1P5_Q16, 3 * FRACTION_BITS + 2) >> 18) / x;
      t2   = (clip_shl(11, 4 * FRACTION_BITS - 1) / x) / x;
      t3   = ((clip_shl(5 * SQRT_1P5_Q16, 5 * FRACTION_BITS + 2) >> 19) / x / x) / x;
      sg   = clip_shl(s2, S2_SHIFT) / g2;
      pos  = clip_add(clip_add(t0, t1), t3);
      neg  = clip_add(clip_add(t2, u64_t'(1) << (S2_SHIFT - 3)), sg);
      v    = (neg >= pos) ? 0 : pos - neg;
      base = clip_mul(v, g) >> FWD_SHIFT;
      if (!arith_ovf) begin
        sum = longint'(base) + mu;
        res = (sum < 0) ? 0 : u64_t'(sum);
      end
    end
    if (arith_ovf || res > u64_t'(PIX_MAX)) begin
      r.value = PIX_MAX;
      r.sat   = 1'b1;
    end else begin
      r.value = res[PIXEL_WIDTH-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count_o++;
  endtask

  assign pending_count_o = expected_pixels.size();

  initial begin
    error_count_o   = 0;
    checked_count_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      inverse_mode = 1'b0;
      gain_q88     = GAIN_W'(256);
      offset_q168  = '0;
      sigma_q88    = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DIRECTION: inverse_mode = cfg_data_i[0];
          REG_GAIN:      gain_q88     = cfg_data_i[GAIN_W-1:0];
          REG_OFFSET:    offset_q168  = cfg_data_i[OFFSET_W-1:0];
          REG_SIGMA:     sigma_q88    = cfg_data_i[SIGMA_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_pixels.push_back(predict_pixel(value_in_i));
      if (out_valid_i && !out_stall_i) begin
        checked_count_o++;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", value_out_i));
        end else begin
          want = expected_pixels.pop_front();
          if (value_out_i !== want.value)
            report_mismatch($sformatf("value_out %h, expected %h", value_out_i, want.value));
          if (saturated_i !== want.sat)
            report_mismatch($sformatf("saturated %b, expected %b", saturated_i, want.sat));
        end
      end
    end
  end

endmodule

// File: sim/generalized_anscombe_transform_core_tb.sv
// ----------------------------------------------------------------------------
// Generalised Anscombe transform core testbench
// Streams directed and random pixels through the core under a series of
// register settings, with random idling on both sides and one long output
// hold-off; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module generalized_anscombe_transform_core_tb;
  import gat_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 300;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [PIXEL_WIDTH-1:0] value_in_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [PIXEL_WIDTH-1:0] value_out_o;
  logic                   saturated_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  int  error_count;
  int  pending_count;
  int  checked_count;
  int  cycle_count = 0;
  int  pixels_sent = 0;
  int  settings_used = 0;
  // When set, neither side idles any more; used for the closing stretch.
  bit  steady_flow = 1'b0;
  // Requests one long hold-off on the result side.
  bit  hold_request = 1'b0;

  always #10 clk_i = ~clk_i;

  generalized_anscombe_transform_core uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .value_in_i,
    .out_valid_o, .out_stall_i, .value_out_o, .saturated_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  gat_result_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .value_in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .value_out_i(value_out_o),
    .saturated_i(saturated_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .error_count_o(error_count), .pending_count_o(pending_count),
    .checked_count_o(checked_count)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side. Short random stall bursts, except when a long hold-off is
  // requested: the core then fills up and must stall its pixel input, while
  // the sender keeps offering pixels.
  always begin
    @(posedge clk_i);
    if (hold_request) begin
      out_stall_i <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      out_stall_i  <= 1'b0;
      hold_request <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Offers one pixel and holds it until the transfer. Valid is only lowered
  // when a gap follows, so back-to-back pixels keep it high throughout.
  task automatic send_pixel(input logic [PIXEL_WIDTH-1:0] pixel);
    in_valid_i <= 1'b1;
    value_in_i <= pixel;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    if (!steady_flow && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Registers may only change with nothing in flight: wait for every result,
  // then idle on before writing all four.
  task automatic apply_setting(input logic dir, input logic [GAIN_W-1:0] gain,
                               input logic [OFFSET_W-1:0] offset,
                               input logic [SIGMA_W-1:0] sigma);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    write_register(REG_DIRECTION, CFG_DATA_W'(dir));
    write_register(REG_GAIN, CFG_DATA_W'(gain));
    write_register(REG_OFFSET, CFG_DATA_W'(offset));
    write_register(REG_SIGMA, CFG_DATA_W'(sigma));
    settings_used++;
  endtask

  // Random pixels: a third are small, where the inverse reciprocal terms and
  // the forward offset crossing matter; the rest cover the full range.
  task automatic send_random_pixels(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 2) == 0) send_pixel(PIXEL_WIDTH'($urandom_range(0, 4095)));
      else send_pixel(PIXEL_WIDTH'($urandom));
    end
  endtask

  initial begin
    // Reset is asserted from the start and released once only.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed forward pixels at the reset setting: extremes, a mid value,
    // one count exactly, the lowest bit alone and two alternating patterns.
    send_pixel('0);
    send_pixel(PIXEL_WIDTH'(1));
    send_pixel(PIXEL_WIDTH'(256));
    send_pixel(PIXEL_WIDTH'(24'h800000));
    send_pixel(PIX_MAX);
    send_pixel(PIXEL_WIDTH'(24'h555555));
    send_pixel(PIXEL_WIDTH'(24'hAAAAAA));

    // Directed inverse pixels: a zero input saturates, tiny inputs drive the
    // reciprocal terms hard, large inputs overflow the pixel range.
    apply_setting(1'b1, GAIN_W'(256), '0, '0);
    send_pixel('0);
    send_pixel(PIXEL_WIDTH'(1));
    send_pixel(PIXEL_WIDTH'(2));
    send_pixel(PIXEL_WIDTH'(128));
    send_pixel(PIXEL_WIDTH'(256));
    send_pixel(PIXEL_WIDTH'(512));
    send_pixel(PIXEL_WIDTH'(24'h004000));
    send_pixel(PIX_MAX);

    // Forward with a negative argument (offset above the pixel) and a zero
    // gain, then the register extremes in both directions.
    apply_setting(1'b0, '0, OFFSET_W'(24'h7FFFFF), '0);
    send_pixel('0);
    send_pixel(PIX_MAX);
    send_random_pixels(35);

    apply_setting(1'b0, GAIN_W'(1), '0, '0);
    send_random_pixels(35);

    // The long hold-off happens under this setting. Enough pixels follow to
    // fill the row and keep offering while the input is stalled.
    apply_setting(1'b0, GAIN_W'(16'hFFFF), OFFSET_W'(24'h800000), SIGMA_W'(16'hFFFF));
    hold_request = 1'b1;
    send_random_pixels(130);

    apply_setting(1'b1, GAIN_W'(1), OFFSET_W'(24'h7FFFFF), SIGMA_W'(16'hFFFF));
    send_random_pixels(35);

    apply_setting(1'b1, GAIN_W'(16'hFFFF), OFFSET_W'(24'h800000), '0);
    send_random_pixels(35);

    apply_setting(1'b1, '0, '0, SIGMA_W'(300));
    send_random_pixels(35);

    // Random settings in both directions.
    for (int p = 0; p < 4; p++) begin
      apply_setting(1'($urandom), GAIN_W'($urandom), OFFSET_W'($urandom),
                    SIGMA_W'($urandom_range(0, 2048)));
      send_random_pixels(15);
    end

    // Closing stretch with no idling on either side.
    apply_setting(1'($urandom), GAIN_W'($urandom_range(64, 1024)), OFFSET_W'($urandom),
                  SIGMA_W'($urandom_range(0, 512)));
    steady_flow = 1'b1;
    send_random_pixels(40);
    in_valid_i <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixels under %0d register settings, both directions.",
             pixels_sent, settings_used + 1);
    $display("Checked %0d results, including one long output hold-off.", checked_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
